### rtl/dov_pkg.sv
// shared types, constants and the angle fold for the orientation vote block
// no dependencies
`default_nettype none

package dov_pkg;

   // capacity and derived widths
   localparam int MAX_SEGMENTS = 64;
   localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
   localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

   // field widths
   localparam int ANGLE_W      = 16;
   localparam int FOLD_W       = 14;
   localparam int TOL_W        = 11;
   localparam int VOTE_W       = 7;
   localparam int SUM_W        = FOLD_W + ADDR_W;
   localparam int DIV_STEP_W   = $clog2(SUM_W + 1);

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(205);

   // q2.13 angle constants
   localparam logic signed [ANGLE_W:0] Q_PI_4  = 17'sd6434;
   localparam logic signed [ANGLE_W:0] Q_3PI_4 = 17'sd19302;
   localparam logic signed [ANGLE_W:0] Q_PI_2  = 17'sd12868;
   localparam logic signed [ANGLE_W:0] Q_PI    = 17'sd25736;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] segment_angle;
      logic                      last_segment;
   } req_type;

   typedef struct packed {
      logic signed [FOLD_W-1:0] correction_angle;
      logic [VOTE_W-1:0]        vote_count;
      logic                     found;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic              mem_wr;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr;
      logic              fetch;
      logic              sweep;
      logic              clear_acc;
      logic              compare;
      logic              clear_best;
      logic              div_start;
      logic              load_rsp;
      logic              found;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_done;
      logic rsp_free;
   } status_type;

   // rotation that brings an angle onto the nearest grid axis
   function automatic logic signed [FOLD_W-1:0] fold_angle(
      input logic signed [ANGLE_W-1:0] a);
      logic signed [ANGLE_W:0] ax;
      logic signed [ANGLE_W:0] mag;
      logic signed [ANGLE_W:0] fp;
      logic signed [ANGLE_W:0] res;
      ax  = {a[ANGLE_W-1], a};
      mag = a[ANGLE_W-1] ? -ax : ax;
      if (mag <= Q_PI_4) begin
         fp = -mag;
      end else if (mag <= Q_3PI_4) begin
         fp = Q_PI_2 - mag;
      end else begin
         fp = Q_PI - mag;
      end
      res = a[ANGLE_W-1] ? -fp : fp;
      return res[FOLD_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/dominant_orientation_vote.sv
// Loading: one angle beat per cycle while idle.
// Vote: on the last beat, a pairwise sweep over the stored angles (one store read per cycle),
// then a bit-serial divide.
// The next set can load while the result waits on the output register.
// Reset (synchronous): tolerance 205, store count zero; the angle store is not cleared.
`default_nettype none

module dominant_orientation_vote
   import dov_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [TOL_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   dov_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_data.last_segment),
      .status    (status),
      .cmd       (cmd)
   );

   dov_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/dov_divider.sv
// restoring divider, one quotient bit per cycle, unsigned
// depends on dov_pkg
`default_nettype none

module dov_divider
   import dov_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  done,
   output logic [SUM_W-1:0]      quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      dsr_ff, dsr_in;
   logic [CNT_W:0]        rem_sh;
   logic                  fits;

   // one shift and subtract step
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      fits    = rem_sh >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_STEP_W'(SUM_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? CNT_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[CNT_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   // done only ever follows a busy cycle
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
   // a division runs to its end before done
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("divider stopped without done");
   // the unit is never restarted mid division
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire

### rtl/dov_datapath.sv
// angle store, pairwise match accumulation, best group tracking, result register
// depends on dov_pkg and dov_divider
`default_nettype none

module dov_datapath
   import dov_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_type          req_data,
   input  wire logic             csr_valid,
   input  wire logic [TOL_W-1:0] csr_wdata,
   input  wire cmd_type          cmd,
   output status_type            status,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data
);

   logic [TOL_W-1:0]         tol_ff;
   logic signed [FOLD_W-1:0] angle_mem_ff [MAX_SEGMENTS];
   logic signed [FOLD_W-1:0] rd_data_ff;
   logic                     fetch_ff;
   logic                     sweep_ff;
   logic signed [FOLD_W-1:0] ai_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]  best_sum_ff, best_sum_in;
   logic [CNT_W-1:0]         best_cnt_ff, best_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff;
   logic signed [FOLD_W:0]   diff;
   logic [FOLD_W:0]          adiff;
   logic                     match;
   logic [SUM_W-1:0]         dvd_mag;
   logic                     div_done;
   logic [SUM_W-1:0]         quo;
   logic [FOLD_W-1:0]        quo_trunc;
   logic signed [FOLD_W-1:0] corr;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_wdata;
      end
   end

   // folded angle store
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         angle_mem_ff[cmd.wr_addr] <= fold_angle(req_data.segment_angle);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= angle_mem_ff[cmd.rd_addr];
   end

   // read kind follows the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_ff <= 1'b0;
         sweep_ff <= 1'b0;
      end else begin
         fetch_ff <= cmd.fetch;
         sweep_ff <= cmd.sweep;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_ff) begin
         ai_ff <= rd_data_ff;
      end
   end

   // match test against the candidate angle
   always_comb begin
      diff  = {ai_ff[FOLD_W-1], ai_ff} - {rd_data_ff[FOLD_W-1], rd_data_ff};
      adiff = diff[FOLD_W] ? unsigned'(-diff) : unsigned'(diff);
      match = adiff <= (FOLD_W+1)'(tol_ff);
   end

   // group accumulation and best group update
   always_comb begin
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      best_sum_in = best_sum_ff;
      best_cnt_in = best_cnt_ff;
      if (cmd.clear_acc) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (sweep_ff && match) begin
         sum_in = sum_ff + SUM_W'(rd_data_ff);
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.clear_best) begin
         best_sum_in = '0;
         best_cnt_in = '0;
      end else if (cmd.compare && (cnt_ff > best_cnt_ff)) begin
         best_sum_in = sum_ff;
         best_cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      best_sum_ff <= best_sum_in;
      best_cnt_ff <= best_cnt_in;
   end

   // mean of the winning group, truncated toward zero
   assign dvd_mag = best_sum_ff[SUM_W-1] ? unsigned'(-best_sum_ff) : unsigned'(best_sum_ff);

   dov_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd_mag),
      .divisor  (best_cnt_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // correction is minus the mean
   always_comb begin
      quo_trunc = quo[FOLD_W-1:0];
      corr      = best_sum_ff[SUM_W-1] ? signed'(quo_trunc) : -signed'(quo_trunc);
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.correction_angle <= (best_cnt_ff == '0) ? '0 : corr;
         rsp_data_ff.vote_count       <= VOTE_W'(best_cnt_ff);
         rsp_data_ff.found            <= cmd.found;
      end
   end

   assign status.div_done = div_done;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/dov_controller.sv
// sequencer: load count, pairwise vote loop, divide and result hand-off
// depends on dov_pkg
`default_nettype none

module dov_controller
   import dov_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_last,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_FETCH     = 3'd1;
   localparam logic [2:0] ST_SWEEP     = 3'd2;
   localparam logic [2:0] ST_DRAIN     = 3'd3;
   localparam logic [2:0] ST_COMPARE   = 3'd4;
   localparam logic [2:0] ST_DIV_START = 3'd5;
   localparam logic [2:0] ST_DIV_WAIT  = 3'd6;
   localparam logic [2:0] ST_RESPOND   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic              room;
   logic [CNT_W-1:0]  loaded_next;

   assign room        = loaded_ff < CNT_W'(MAX_SEGMENTS);
   assign loaded_next = room ? loaded_ff + 1'b1 : loaded_ff;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      loaded_in      = loaded_ff;
      n_in           = n_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.wr_addr    = loaded_ff[ADDR_W-1:0];
      cmd.found      = n_ff != '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.mem_wr = room;
               loaded_in  = loaded_next;
               if (req_last) begin
                  n_in           = loaded_next;
                  i_in           = '0;
                  cmd.clear_best = 1'b1;
                  state_in       = (loaded_next == '0) ? ST_DIV_START : ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.rd_addr   = i_ff;
            cmd.fetch     = 1'b1;
            cmd.clear_acc = 1'b1;
            j_in          = '0;
            state_in      = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.rd_addr = j_ff;
            cmd.sweep   = 1'b1;
            j_in        = j_ff + 1'b1;
            if ({1'b0, j_ff} == n_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            if ({1'b0, i_ff} == n_ff - 1'b1) begin
               state_in = ST_DIV_START;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               loaded_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         loaded_ff <= '0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
      end
   end

   // loop counters
   always_ff @(posedge clock) begin
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
   end

`ifndef SYNTHESIS
   // sweep index stays inside the stored set
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> ({1'b0, j_ff} < n_ff))
      else $error("sweep index beyond stored angles");
   // store never overfills
   assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CNT_W'(MAX_SEGMENTS))
      else $error("loaded count above capacity");
   // a pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("result loaded over an untaken result");
   // a write beat grows the count by one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && room && !req_last) |=> (loaded_ff == $past(loaded_ff) + 1'b1))
      else $error("loaded count did not advance");
`endif

endmodule

`default_nettype wire

### bench/tb.sv
// testbench for dominant_orientation_vote: directed rows, then random segment sets
// under several tolerances, checked beat by beat against a predictor or preset values
// depends on dov_pkg and dominant_orientation_vote
`timescale 1ns / 100ps

module tb
   import dov_pkg::*;
();

   // q2.13 angle constants of the fold
   localparam int QUARTER_PI_Q       = 6434;
   localparam int HALF_PI_Q          = 12868;
   localparam int THREE_QUARTER_PI_Q = 19302;
   localparam int PI_Q               = 25736;

   // the longest vote (64 angles) runs with no beat at all; the watchdog limit covers it
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 32;
   localparam int DRAIN_CYCLES   = 5000;
   localparam int PHASE_ITEMS    = 245;

   typedef struct {
      logic signed [ANGLE_W-1:0] angle;
      bit                        last_flag;
      bit                        typed;
      rsp_type                   value;
   } directed_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [TOL_W-1:0] csr_wdata;

   // predictor state
   int folded_store [MAX_SEGMENTS];
   int stored_count = 0;
   int match_tol    = 205;

   rsp_type          pending_corrections [$];
   directed_row_type preset_results [$];
   int               mismatch_count = 0;
   int               quiet_cycles   = 0;
   int               sent_items     = 0;
   bit               sender_calm    = 1'b0;

   int boundary_angles [12] = '{6433, 6434, 6435, 19301, 19302, 19303, 25736,
                                -6434, -6435, -19302, -19303, -25736};

   // grid-axis extremes with values read straight off the fold, then small sets
   directed_row_type opening_rows [20] = '{
      '{16'sd0,      1'b1, 1'b1, '{14'sd0,     7'd1, 1'b1}},
      '{16'sd6434,   1'b1, 1'b1, '{14'sd6434,  7'd1, 1'b1}},
      '{-16'sd6434,  1'b1, 1'b1, '{-14'sd6434, 7'd1, 1'b1}},
      '{16'sd6435,   1'b1, 1'b1, '{-14'sd6433, 7'd1, 1'b1}},
      '{16'sd19302,  1'b1, 1'b1, '{14'sd6434,  7'd1, 1'b1}},
      '{16'sd19303,  1'b1, 1'b1, '{-14'sd6433, 7'd1, 1'b1}},
      '{16'sd25736,  1'b1, 1'b1, '{14'sd0,     7'd1, 1'b1}},
      '{-16'sd25736, 1'b1, 1'b1, '{14'sd0,     7'd1, 1'b1}},
      '{16'sd32767,  1'b1, 1'b1, '{14'sd7031,  7'd1, 1'b1}},
      '{16'sh8000,   1'b1, 1'b1, '{-14'sd7032, 7'd1, 1'b1}},
      // four angles, two of them on different axes folding to the same rotation
      '{16'sd100,    1'b0, 1'b0, '0},
      '{16'sd12968,  1'b0, 1'b0, '0},
      '{-16'sd500,   1'b0, 1'b0, '0},
      '{16'sd6400,   1'b1, 1'b0, '0},
      // negative sum, mean truncated toward zero
      '{16'sd1,      1'b0, 1'b0, '0},
      '{16'sd2,      1'b1, 1'b0, '0},
      // tie, first angle wins
      '{16'sd1000,   1'b0, 1'b0, '0},
      '{16'sd3000,   1'b1, 1'b0, '0},
      // folds on both sides of the pi/4 seam merging into one group
      '{-16'sd19303, 1'b0, 1'b0, '0},
      '{16'sd6434,   1'b1, 1'b0, '0}
   };

   dominant_orientation_vote u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // rotation onto the nearest grid axis
   function automatic int fold_segment(input int a);
      int mag;
      int r;
      mag = (a < 0) ? -a : a;
      if (mag <= QUARTER_PI_Q) begin
         r = -mag;
      end else if (mag <= THREE_QUARTER_PI_Q) begin
         r = HALF_PI_Q - mag;
      end else begin
         r = PI_Q - mag;
      end
      return (a < 0) ? -r : r;
   endfunction

   // pairwise vote over the stored folds, first strict maximum wins
   function automatic rsp_type tally_orientation();
      int best_n;
      int best_mean;
      int n;
      int sum;
      int d;
      rsp_type r;
      best_n    = 0;
      best_mean = 0;
      for (int i = 0; i < stored_count; i++) begin
         n   = 0;
         sum = 0;
         for (int j = 0; j < stored_count; j++) begin
            d = folded_store[i] - folded_store[j];
            if (d < 0) d = -d;
            if (d <= match_tol) begin
               n++;
               sum += folded_store[j];
            end
         end
         if (n > best_n) begin
            best_n    = n;
            best_mean = sum / n;
         end
      end
      r.correction_angle = FOLD_W'(-best_mean);
      r.vote_count       = VOTE_W'(best_n);
      r.found            = (stored_count > 0);
      return r;
   endfunction

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // beat monitor: checks results, tracks config and predicts per segment beat
   always @(posedge clock) begin : monitor
      rsp_type          want;
      rsp_type          predicted;
      directed_row_type preset;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_corrections.size() == 0) begin
               $error("result beat with no result pending");
               mismatch_count++;
            end else begin
               want = pending_corrections.pop_front();
               report_field("correction_angle", want.correction_angle,
                            rsp_data.correction_angle);
               report_field("vote_count", want.vote_count, rsp_data.vote_count);
               report_field("found", want.found, rsp_data.found);
            end
         end
         if (csr_valid && csr_ready) begin
            match_tol = int'(csr_wdata);
         end
         if (req_valid && req_ready) begin
            if (stored_count < MAX_SEGMENTS) begin
               folded_store[stored_count] = fold_segment(req_data.segment_angle);
               stored_count++;
            end
            if (req_data.last_segment) begin
               predicted    = tally_orientation();
               stored_count = 0;
               if (preset_results.size() != 0) begin
                  preset = preset_results.pop_front();
                  if (preset.typed) predicted = preset.value;
               end
               pending_corrections.insert(pending_corrections.size(), predicted);
            end
         end
         // watchdog on cycles without any beat
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // result side: random stalls, with calm stretches
   initial begin : receiver
      int  gap;
      bit  calm;
      rsp_ready = 1'b0;
      calm      = 1'b0;
      @(posedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if ($urandom_range(0, 7) == 0) calm = !calm;
      end
   end

   // one segment beat; valid stays up across back-to-back beats
   task automatic send_segment(input logic signed [ANGLE_W-1:0] angle, input bit last_flag);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{segment_angle: angle, last_segment: last_flag};
      do @(posedge clock); while (!(req_valid && req_ready));
      sent_items++;
   endtask

   // drain all results, let the block settle, then write the tolerance
   task automatic write_tolerance(input int tol);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_corrections.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= TOL_W'(tol);
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   // one set: mostly clustered angles around a random base, some noise and edges
   task automatic run_random_set();
      int set_size;
      int base;
      int jitter;
      int pick;
      int raw;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         set_size = $urandom_range(1, 8);
      end else if (pick < 95) begin
         set_size = $urandom_range(9, 24);
      end else if (pick < 98) begin
         set_size = $urandom_range(25, MAX_SEGMENTS);
      end else begin
         set_size = $urandom_range(MAX_SEGMENTS + 1, MAX_SEGMENTS + 8);
      end
      base        = int'($urandom_range(0, 2 * PI_Q)) - PI_Q;
      jitter      = $urandom_range(0, 1200);
      sender_calm = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < set_size; k++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1:    raw = int'($urandom);
            2:       raw = int'($urandom_range(0, 2 * PI_Q)) - PI_Q;
            3:       raw = boundary_angles[$urandom_range(0, 11)];
            4:       raw = base;
            default: raw = base + int'($urandom_range(0, 4)) * HALF_PI_Q - 2 * HALF_PI_Q
                           + int'($urandom_range(0, 2 * jitter)) - jitter;
         endcase
         send_segment(ANGLE_W'(raw), k == set_size - 1);
      end
   endtask

   // reset, directed rows, then random phases under several tolerances
   initial begin : stimulus
      int tol_plan [7];
      int target;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 20; i++) begin
         if (opening_rows[i].last_flag) begin
            preset_results.insert(preset_results.size(), opening_rows[i]);
         end
         send_segment(opening_rows[i].angle, opening_rows[i].last_flag);
      end

      tol_plan = '{0, 2047, 1024, 1, $urandom_range(0, 1024), $urandom_range(0, 300), 205};
      for (int p = 0; p < 7; p++) begin
         write_tolerance(tol_plan[p]);
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target) run_random_set();
      end

      // wait out every result, then wait longer than the longest vote for strays
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_corrections.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
